[rtl/tvlq_pkg.sv]
// ---------------------------------------------------------------------------
// tvlq_pkg
// Shared constants for the tetrahedron volume / rms edge quality pipeline.
// ---------------------------------------------------------------------------
package tvlq_pkg;

  localparam int unsigned NUM_VERT  = 4;
  localparam int unsigned NUM_AXIS  = 3;
  localparam int unsigned NUM_EDGE  = 6;
  localparam int unsigned NUM_FIELD = NUM_VERT * NUM_AXIS;

  // edge endpoints, in vertex order
  localparam int unsigned EDGE_A [NUM_EDGE] = '{0, 0, 0, 1, 1, 2};
  localparam int unsigned EDGE_B [NUM_EDGE] = '{1, 2, 3, 2, 3, 3};

  // quality^2 * S^3 <= QUAL_SCALE * D^2 * 2^(2F); QUAL_SCALE = 432 = 256+128+32+16
  localparam int unsigned QUAL_SCALE_BITS = 9;

endpackage

[rtl/tet_volume_lrms_quality.sv]
// ---------------------------------------------------------------------------
// tet_volume_lrms_quality
// Pipelined tetrahedron quality: 12*sqrt(3)*D / S^(3/2) as signed fixed point.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one tetrahedron per item, twelve signed coordinates in in_tdata,
//           p0_x in the lowest bits, then p0_y .. p3_z.
//   out_* : one result per item; out_tdata holds quality (signed, two integer
//           bits, QUAL_FRAC_BITS fraction bits), out_tuser the degenerate flag.
//   The pipeline is nine stages of determinant, edge sum and product
//   arithmetic, one compare and subtract stage per quality bit, and the
//   output register. Throughput is one item per cycle unless stalled;
//   every stage advances together.
//   When out_tready is low with a result waiting the whole pipeline holds and
//   in_tready drops; bubbles inside the pipeline stay where they are until
//   the output drains.
//   Reset (rst_n low, synchronous) clears all valid bits; nothing else is
//   needed since items carry no state between them.
// ---------------------------------------------------------------------------
module tet_volume_lrms_quality
  import tvlq_pkg::*;
#(
  parameter int COORD_BITS     = 20,
  parameter int QUAL_FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z
  input  logic [((NUM_FIELD*COORD_BITS+7)/8)*8-1:0] in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // quality
  output logic [((QUAL_FRAC_BITS+2+7)/8)*8-1:0]     out_tdata,
  // degenerate
  output logic                 out_tuser
);

  localparam int CB   = COORD_BITS;
  localparam int F    = QUAL_FRAC_BITS;
  localparam int QW   = F + 2;
  localparam int OTW  = ((QW + 7) / 8) * 8;
  localparam int DFW  = CB + 1;
  localparam int PW   = 2 * DFW;
  localparam int CFW  = PW + 1;
  localparam int TW   = DFW + CFW;
  localparam int DW   = TW + 2;
  localparam int MW   = DW;
  localparam int ESW  = PW + 2;
  localparam int SW   = ESW + 3;
  localparam int S2W  = 2 * SW;
  localparam int S3W  = 3 * SW;
  localparam int D2W  = 2 * MW;
  localparam int XW   = D2W + QUAL_SCALE_BITS + 2 * F + 4;
  localparam int SH   = (SW + 1) / 2;
  localparam int SHW  = SW - SH;
  localparam int C3   = (S2W + 2) / 3;
  localparam int MH   = (MW + 1) / 2;
  localparam int MHW  = MW - MH;

  logic en;
  assign en        = out_tready || !out_tvalid;
  assign in_tready = en;

  // ---------------- stage 1: differences
  logic signed [CB-1:0]  pt [NUM_VERT][NUM_AXIS];
  logic signed [DFW-1:0] s1_d_nxt [3][NUM_AXIS];
  logic signed [DFW-1:0] s1_e_nxt [NUM_EDGE][NUM_AXIS];
  logic signed [DFW-1:0] s1_d_r   [3][NUM_AXIS];
  logic signed [DFW-1:0] s1_e_r   [NUM_EDGE][NUM_AXIS];
  logic                  v1_r;

  always_comb begin
    for (int i = 0; i < NUM_VERT; i++) begin
      for (int k = 0; k < NUM_AXIS; k++) begin
        pt[i][k] = $signed(in_tdata[(i*NUM_AXIS+k)*CB +: CB]);
      end
    end
    for (int k = 0; k < NUM_AXIS; k++) begin
      s1_d_nxt[0][k] = DFW'(pt[0][k]) - DFW'(pt[3][k]);
      s1_d_nxt[1][k] = DFW'(pt[2][k]) - DFW'(pt[3][k]);
      s1_d_nxt[2][k] = DFW'(pt[1][k]) - DFW'(pt[3][k]);
    end
    for (int e = 0; e < NUM_EDGE; e++) begin
      for (int k = 0; k < NUM_AXIS; k++) begin
        s1_e_nxt[e][k] = DFW'(pt[EDGE_A[e]][k]) - DFW'(pt[EDGE_B[e]][k]);
      end
    end
  end

  // ---------------- stage 2: cross products, squared edges
  logic signed [PW-1:0]  s2_p_nxt [6];
  logic        [ESW-1:0] s2_e_nxt [NUM_EDGE];
  logic signed [PW-1:0]  s2_p_r   [6];
  logic        [ESW-1:0] s2_e_r   [NUM_EDGE];
  logic signed [DFW-1:0] s2_x_r   [3];
  logic                  v2_r;
  logic signed [PW-1:0]  sq [NUM_EDGE][NUM_AXIS];

  always_comb begin
    s2_p_nxt[0] = s1_d_r[1][1] * s1_d_r[2][2];
    s2_p_nxt[1] = s1_d_r[1][2] * s1_d_r[2][1];
    s2_p_nxt[2] = s1_d_r[2][1] * s1_d_r[0][2];
    s2_p_nxt[3] = s1_d_r[2][2] * s1_d_r[0][1];
    s2_p_nxt[4] = s1_d_r[0][1] * s1_d_r[1][2];
    s2_p_nxt[5] = s1_d_r[0][2] * s1_d_r[1][1];
    for (int e = 0; e < NUM_EDGE; e++) begin
      for (int k = 0; k < NUM_AXIS; k++) begin
        sq[e][k] = s1_e_r[e][k] * s1_e_r[e][k];
      end
      s2_e_nxt[e] = ESW'($unsigned(sq[e][0])) + ESW'($unsigned(sq[e][1]))
                  + ESW'($unsigned(sq[e][2]));
    end
  end

  // ---------------- stage 3: cofactors, edge sum
  logic signed [CFW-1:0] s3_c_nxt [3];
  logic        [SW-1:0]  s3_s_nxt;
  logic signed [CFW-1:0] s3_c_r   [3];
  logic signed [DFW-1:0] s3_x_r   [3];
  logic        [SW-1:0]  s3_s_r;
  logic                  v3_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s3_c_nxt[i] = CFW'(s2_p_r[2*i]) - CFW'(s2_p_r[2*i+1]);
    end
    s3_s_nxt = '0;
    for (int e = 0; e < NUM_EDGE; e++) begin
      s3_s_nxt = s3_s_nxt + SW'(s2_e_r[e]);
    end
  end

  // ---------------- stage 4: determinant terms, S^2 partials
  logic signed [TW-1:0]      s4_t_nxt [3];
  logic signed [TW-1:0]      s4_t_r   [3];
  logic [2*SH-1:0]           s4_ll_r;
  logic [SW-1:0]             s4_lh_r;
  logic [2*SHW-1:0]          s4_hh_r;
  logic [SW-1:0]             s4_s_r;
  logic                      v4_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s4_t_nxt[i] = s3_x_r[i] * s3_c_r[i];
    end
  end

  // ---------------- stage 5: determinant, S^2
  logic signed [DW-1:0] s5_d_nxt;
  logic [S2W-1:0]       s5_s2_nxt;
  logic signed [DW-1:0] s5_d_r;
  logic [S2W-1:0]       s5_s2_r;
  logic [SW-1:0]        s5_s_r;
  logic                 v5_r;

  assign s5_d_nxt  = DW'(s4_t_r[0]) + DW'(s4_t_r[1]) + DW'(s4_t_r[2]);
  assign s5_s2_nxt = (S2W'(s4_hh_r) << (2*SH)) + (S2W'(s4_lh_r) << (SH+1))
                   + S2W'(s4_ll_r);

  // ---------------- stage 6: magnitude, S^3 partials
  logic [MW-1:0]        s6_m_nxt;
  logic [MW-1:0]        s6_m_r;
  logic                 s6_n_r;
  logic                 s6_z_r;
  logic [C3+SH-1:0]     s6_pp_r [3][2];
  logic                 v6_r;
  logic [C3-1:0]        s2c [3];
  logic [SH-1:0]        s1c [2];

  assign s6_m_nxt = s5_d_r[DW-1] ? MW'(-s5_d_r) : MW'(s5_d_r);

  always_comb begin
    s2c[0] = s5_s2_r[C3-1:0];
    s2c[1] = s5_s2_r[2*C3-1:C3];
    s2c[2] = C3'(s5_s2_r[S2W-1:2*C3]);
    s1c[0] = s5_s_r[SH-1:0];
    s1c[1] = SH'(s5_s_r[SW-1:SH]);
  end

  // ---------------- stage 7: D^2 partials, S^3
  logic [S3W-1:0]       s7_s3_nxt;
  logic [2*MH-1:0]      s7_ll_r;
  logic [MW-1:0]        s7_lh_r;
  logic [2*MHW-1:0]     s7_hh_r;
  logic [S3W-1:0]       s7_s3_r;
  logic                 s7_n_r;
  logic                 s7_z_r;
  logic                 v7_r;

  always_comb begin
    s7_s3_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 2; j++) begin
        s7_s3_nxt = s7_s3_nxt + (S3W'(s6_pp_r[i][j]) << (i*C3 + j*SH));
      end
    end
  end

  // ---------------- stage 8: D^2
  logic [D2W-1:0] s8_d2_r;
  logic [S3W-1:0] s8_s3_r;
  logic           s8_n_r;
  logic           s8_z_r;
  logic           v8_r;

  // ---------------- search stages, index 0 fed by stage 9
  logic [XW-1:0]  sr_r [F+2];
  logic [XW-1:0]  st_r [F+2];
  logic [XW-1:0]  ss_r [F+2];
  logic [F:0]     sq_r [F+2];
  logic           sn_r [F+2];
  logic           sz_r [F+2];
  logic           sv_r [F+2];
  logic [XW-1:0]  r0_nxt;
  logic [XW-1:0]  d2x;

  assign d2x    = XW'(s8_d2_r);
  assign r0_nxt = ((d2x << 8) + (d2x << 7) + (d2x << 5) + (d2x << 4)) << (2*F);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d_r <= s1_d_nxt;
      s1_e_r <= s1_e_nxt;
      s2_p_r <= s2_p_nxt;
      s2_e_r <= s2_e_nxt;
      for (int i = 0; i < 3; i++) begin
        s2_x_r[i] <= s1_d_r[i][0];
      end
      s3_c_r  <= s3_c_nxt;
      s3_s_r  <= s3_s_nxt;
      s3_x_r  <= s2_x_r;
      s4_t_r  <= s4_t_nxt;
      s4_ll_r <= s3_s_r[SH-1:0] * s3_s_r[SH-1:0];
      s4_lh_r <= SW'(s3_s_r[SH-1:0] * s3_s_r[SW-1:SH]);
      s4_hh_r <= s3_s_r[SW-1:SH] * s3_s_r[SW-1:SH];
      s4_s_r  <= s3_s_r;
      s5_d_r  <= s5_d_nxt;
      s5_s2_r <= s5_s2_nxt;
      s5_s_r  <= s4_s_r;
      s6_m_r  <= s6_m_nxt;
      s6_n_r  <= s5_d_r[DW-1];
      s6_z_r  <= (s5_d_r == '0);
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 2; j++) begin
          s6_pp_r[i][j] <= s2c[i] * s1c[j];
        end
      end
      s7_ll_r  <= s6_m_r[MH-1:0] * s6_m_r[MH-1:0];
      s7_lh_r  <= MW'(s6_m_r[MH-1:0] * s6_m_r[MW-1:MH]);
      s7_hh_r  <= s6_m_r[MW-1:MH] * s6_m_r[MW-1:MH];
      s7_s3_r  <= s7_s3_nxt;
      s7_n_r   <= s6_n_r;
      s7_z_r   <= s6_z_r;
      s8_d2_r  <= (D2W'(s7_hh_r) << (2*MH)) + (D2W'(s7_lh_r) << (MH+1))
                + D2W'(s7_ll_r);
      s8_s3_r  <= s7_s3_r;
      s8_n_r   <= s7_n_r;
      s8_z_r   <= s7_z_r;
      sr_r[0]  <= r0_nxt;
      st_r[0]  <= '0;
      ss_r[0]  <= XW'(s8_s3_r);
      sq_r[0]  <= '0;
      sn_r[0]  <= s8_n_r;
      sz_r[0]  <= s8_z_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      v5_r    <= 1'b0;
      v6_r    <= 1'b0;
      v7_r    <= 1'b0;
      v8_r    <= 1'b0;
      sv_r[0] <= 1'b0;
    end else if (en) begin
      v1_r    <= in_tvalid;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      v4_r    <= v3_r;
      v5_r    <= v4_r;
      v6_r    <= v5_r;
      v7_r    <= v6_r;
      v8_r    <= v7_r;
      sv_r[0] <= v8_r;
    end
  end

  // one quality bit per stage, MSB first; residual and Q*S^3 updated by shifts
  for (genvar j = 0; j <= F; j++) begin : g_bit
    localparam int K = F - j;
    logic [XW-1:0] cand;
    logic          take;

    assign cand = (ss_r[j] << (2*K)) + (st_r[j] << (K+1));
    assign take = (cand <= sr_r[j]);

    always_ff @(posedge clk) begin
      if (en) begin
        sr_r[j+1] <= take ? sr_r[j] - cand : sr_r[j];
        st_r[j+1] <= take ? st_r[j] + (ss_r[j] << K) : st_r[j];
        sq_r[j+1] <= take ? sq_r[j] | ((F+1)'(1) << K) : sq_r[j];
        ss_r[j+1] <= ss_r[j];
        sn_r[j+1] <= sn_r[j];
        sz_r[j+1] <= sz_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[j+1] <= 1'b0;
      end else if (en) begin
        sv_r[j+1] <= sv_r[j];
      end
    end
  end

  // ---------------- output register
  logic [F:0]           qm;
  logic signed [QW-1:0] qual_nxt;
  logic [OTW-1:0]       out_tdata_r;
  logic                 out_tuser_r;
  logic                 out_tvalid_r;

  always_comb begin
    qm = sq_r[F+1][F] ? {1'b1, {F{1'b0}}} : sq_r[F+1];
    if (sz_r[F+1]) begin
      qual_nxt = '0;
    end else if (sn_r[F+1]) begin
      qual_nxt = -$signed({1'b0, qm});
    end else begin
      qual_nxt = $signed({1'b0, qm});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= OTW'($unsigned(qual_nxt));
      out_tuser_r <= sz_r[F+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= sv_r[F+1];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // ---------------- assertions
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[QW-1:0] == '0)
    else $error("degenerate result with nonzero quality");

  a_qual_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[QW-1:0]) <= $signed(QW'(1) << F)) &&
                   ($signed(out_tdata[QW-1:0]) >= -$signed(QW'(1) << F)))
    else $error("quality magnitude above one");

  a_zero_rhs: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r[0] && sz_r[0] |-> sr_r[0] == '0)
    else $error("zero determinant with nonzero search bound");

endmodule

[verif/testbench.sv]
// ---------------------------------------------------------------------------
// testbench
// Stream test of tet_volume_lrms_quality against an exact integer predictor.
// ---------------------------------------------------------------------------
// Tetrahedra are queued by an initial block: a directed set first, then
// random ones. Coordinates are full range, small, near regular, or
// degenerate. A clocked driver presents them with random gaps. A clocked
// monitor stalls the result side at random and checks each result against
// the oldest expected quality and degenerate flag.
// ---------------------------------------------------------------------------
module testbench;
  import tvlq_pkg::*;

  localparam int CB       = 20;
  localparam int QF       = 16;
  localparam int IN_W     = ((NUM_FIELD*CB+7)/8)*8;
  localparam int OUT_W    = ((QF+2+7)/8)*8;
  localparam int LATENCY  = QF + 11;
  localparam int WD_LIMIT = 4000;
  localparam int N_RANDOM = 1400;

  typedef logic signed [CB-1:0] coord_t;
  typedef struct {
    coord_t c [NUM_FIELD];
    bit     drain_first;
  } tet_t;
  typedef struct {
    logic [OUT_W-1:0] quality;
    logic             degenerate;
  } qual_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tuser;

  tet_t  pending_tets [$];
  qual_t expected_quals [$];
  int    n_errors = 0;
  int    idle_cycles = 0;
  int    send_gap = 0;
  int    stall_left = 0;
  bit    send_burst = 0;
  bit    recv_burst = 0;
  bit    stim_done = 0;

  tet_volume_lrms_quality dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic qual_t tet_quality(tet_t t);
    logic signed [127:0] ad [3];
    logic signed [127:0] bd [3];
    logic signed [127:0] cd [3];
    logic signed [127:0] det;
    logic signed [127:0] d;
    logic [255:0] mag, s, s3, rhs, lo, hi, mid;
    qual_t r;
    s = '0;
    for (int k = 0; k < 3; k++) begin
      ad[k] = t.c[k]   - t.c[9+k];
      bd[k] = t.c[6+k] - t.c[9+k];
      cd[k] = t.c[3+k] - t.c[9+k];
    end
    det = ad[0] * (bd[1]*cd[2] - bd[2]*cd[1])
        + bd[0] * (cd[1]*ad[2] - cd[2]*ad[1])
        + cd[0] * (ad[1]*bd[2] - ad[2]*bd[1]);
    r.quality = '0;
    r.degenerate = (det == 0);
    if (det == 0) return r;
    mag = (det < 0) ? 256'(-det) : 256'(det);
    for (int i = 0; i < NUM_EDGE; i++) begin
      for (int k = 0; k < 3; k++) begin
        d = t.c[EDGE_A[i]*3+k] - t.c[EDGE_B[i]*3+k];
        s = s + 256'(d*d);
      end
    end
    s3 = s * s * s;
    rhs = ((mag * mag) * 256'd432) << (2*QF);
    lo = '0;
    hi = 256'd1 << QF;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if ((mid * mid) * s3 <= rhs) lo = mid;
      else hi = mid - 1;
    end
    if (det < 0) lo = -lo;
    r.quality = OUT_W'(lo[QF+1:0]);
    return r;
  endfunction

  function automatic int pick_wait();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // driver
  always @(posedge clk) begin
    logic [IN_W-1:0] word;
    logic            nvalid;
    tet_t            t;
    nvalid = in_tvalid;
    word = in_tdata;
    if (!rst_n) begin
      nvalid = 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) send_burst = !send_burst;
      if (in_tvalid && in_tready) begin
        t = pending_tets.pop_front();
        expected_quals.push_back(tet_quality(t));
        nvalid = 1'b0;
        send_gap = send_burst ? 0 : pick_wait();
      end
      if (!nvalid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_tets.size() > 0 &&
                     !(pending_tets[0].drain_first && expected_quals.size() > 0)) begin
          for (int i = 0; i < NUM_FIELD; i++) word[i*CB +: CB] = pending_tets[0].c[i];
          nvalid = 1'b1;
        end
      end
    end
    in_tvalid <= nvalid;
    in_tdata  <= word;
  end

  // monitor
  always @(posedge clk) begin
    qual_t e;
    logic  nready;
    nready = out_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready || out_tvalid && out_tready) idle_cycles = 0;
      else idle_cycles++;
      if (out_tvalid && out_tready) begin
        if (expected_quals.size() == 0) begin
          report("unexpected result", out_tdata, '0);
        end else begin
          e = expected_quals.pop_front();
          if (out_tdata !== e.quality) report("quality", out_tdata, e.quality);
          if (out_tuser !== e.degenerate) begin
            report("degenerate", OUT_W'(out_tuser), OUT_W'(e.degenerate));
          end
        end
      end
      if ($urandom_range(0, 199) == 0) recv_burst = !recv_burst;
      if (stall_left > 0) begin
        stall_left--;
        nready = 1'b0;
      end else begin
        stall_left = recv_burst ? 0 : pick_wait();
        nready = (stall_left == 0);
      end
      if (idle_cycles >= WD_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
    out_tready <= nready;
  end

  function automatic tet_t make_tet(int v [NUM_FIELD]);
    tet_t t;
    for (int i = 0; i < NUM_FIELD; i++) t.c[i] = coord_t'(v[i]);
    t.drain_first = 0;
    return t;
  endfunction

  function automatic coord_t rnd_coord(int span);
    if (span == 0) return coord_t'($urandom);
    return coord_t'($urandom_range(0, 2*span) - span);
  endfunction

  initial begin
    tet_t t;
    int   k, mode, span, dx;
    int   mx = 524287;
    int   mn = -524288;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;

    // all zero, regular both orientations, extremes, coplanar, repeated vertex
    pending_tets.push_back(make_tet('{0,0,0, 0,0,0, 0,0,0, 0,0,0}));
    pending_tets.push_back(make_tet('{1,1,1, 1,-1,-1, -1,1,-1, -1,-1,1}));
    pending_tets.push_back(make_tet('{1,1,1, -1,1,-1, 1,-1,-1, -1,-1,1}));
    pending_tets.push_back(make_tet('{mx,mx,mx, mx,-mx,-mx, -mx,mx,-mx, -mx,-mx,mx}));
    pending_tets.push_back(make_tet('{mx,mx,mx, -mx,mx,-mx, mx,-mx,-mx, -mx,-mx,mx}));
    pending_tets.push_back(make_tet('{mn,mn,mn, mx,mn,mn, mn,mx,mn, mn,mn,mx}));
    pending_tets.push_back(make_tet('{mn,mn,mn, mn,mx,mn, mx,mn,mn, mn,mn,mx}));
    pending_tets.push_back(make_tet('{mx,mx,mx, mn,mn,mn, mx,mn,mx, mn,mx,mn}));
    pending_tets.push_back(make_tet('{mn,mn,mn, mn,mn,mn, mn,mn,mn, mn,mn,mn}));
    pending_tets.push_back(make_tet('{mx,mx,mx, mx,mx,mx, mx,mx,mx, mx,mx,mx}));
    pending_tets.push_back(make_tet('{0,0,0, 5,0,0, 0,7,0, 3,2,0}));
    pending_tets.push_back(make_tet('{0,0,0, 1,1,1, 2,2,2, 9,-4,3}));
    pending_tets.push_back(make_tet('{3,4,5, 3,4,5, 1,0,2, 7,7,7}));
    pending_tets.push_back(make_tet('{0,0,0, 1,0,0, 0,1,0, 0,0,1}));
    pending_tets.push_back(make_tet('{0,0,0, 0,1,0, 1,0,0, 0,0,1}));
    pending_tets.push_back(make_tet('{0,0,0, mx,0,0, 0,mx,0, 0,0,1}));
    pending_tets.push_back(make_tet('{0,0,0, 1,0,0, 0,1,0, mn,mn,1}));
    pending_tets.push_back(make_tet('{-1,-1,-1, 0,0,0, 1,0,0, 0,1,0}));

    for (int n = 0; n < N_RANDOM; n++) begin
      mode = $urandom_range(0, 9);
      span = ($urandom_range(0, 3) == 0) ? 0 : (1 << $urandom_range(1, 18));
      for (int i = 0; i < NUM_FIELD; i++) t.c[i] = rnd_coord(span);
      if (mode < 3) begin
        // near regular, random scale, orientation and small jitter
        k = $urandom_range(1, 250000);
        if ($urandom_range(0, 1)) k = -k;
        t = make_tet('{k,k,k, k,-k,-k, -k,k,-k, -k,-k,k});
        for (int i = 0; i < NUM_FIELD; i++) t.c[i] = t.c[i] + coord_t'($urandom_range(0, 20) - 10);
      end else if (mode == 3) begin
        // coplanar: p3 = p1 + p2 - p0
        for (int i = 0; i < NUM_FIELD; i++) t.c[i] = rnd_coord(100000);
        for (int a = 0; a < 3; a++) t.c[9+a] = t.c[3+a] + t.c[6+a] - t.c[a];
      end else if (mode == 4) begin
        // repeated vertex
        k = $urandom_range(1, 3);
        for (int a = 0; a < 3; a++) t.c[k*3+a] = t.c[a];
      end else if (mode == 5) begin
        // flat sliver
        dx = $urandom_range(0, 3);
        for (int i = 0; i < NUM_VERT; i++) t.c[i*3+2] = t.c[2] + coord_t'(i == dx);
      end
      t.drain_first = (n == 300 || n == 900);
      pending_tets.push_back(t);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_tets.size() > 0 || in_tvalid) @(posedge clk);
    while (expected_quals.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (n_errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
